// ===== hw/rtl/lu_doolittle_factor_3x3_assert.svh =====
// Assertion macros shared by the LU factor RTL.
`ifndef LU_DOOLITTLE_FACTOR_3X3_ASSERT_SVH
`define LU_DOOLITTLE_FACTOR_3X3_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LUDF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LUDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ludf_pkg.sv =====
// Types, constants and helper functions for the 3x3 LU factor pipeline.
`timescale 1ns / 1ps
package ludf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [63:0] NEG_MAG = 64'h0000_8000_0000_0000;
    localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] BIG_MAG = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic signed [15:0] coef_r0c0;
        logic signed [15:0] coef_r0c1;
        logic signed [15:0] coef_r0c2;
        logic signed [15:0] coef_r1c0;
        logic signed [15:0] coef_r1c1;
        logic signed [15:0] coef_r1c2;
        logic signed [15:0] coef_r2c0;
        logic signed [15:0] coef_r2c1;
        logic signed [15:0] coef_r2c2;
    } t_coef;

    typedef struct packed {
        logic signed [47:0] upper_r0c0;
        logic signed [47:0] upper_r0c1;
        logic signed [47:0] upper_r0c2;
        logic signed [47:0] upper_r1c1;
        logic signed [47:0] upper_r1c2;
        logic signed [47:0] upper_r2c2;
        logic signed [47:0] lower_r1c0;
        logic signed [47:0] lower_r2c0;
        logic signed [47:0] lower_r2c1;
        logic               pivot_zero;
        logic               saturated;
    } t_result;

    typedef struct packed {
        logic               sat;
        logic signed [47:0] val;
    } t_clip;

    // Everything the second division and the tail of the pipe need.
    typedef struct packed {
        logic signed [15:0] a00;
        logic signed [15:0] a01;
        logic signed [15:0] a02;
        logic signed [47:0] l10;
        logic signed [47:0] l20;
        logic signed [47:0] u11;
        logic signed [47:0] u12;
        logic signed [63:0] r22;
        logic               neg21;
        logic               z0;
        logic               sat;
    } t_mid;

    typedef struct packed {
        t_mid               mid;
        logic signed [47:0] l21;
        logic               sat21;
    } t_mid2;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(~v + 16'sd1) : v;
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? 48'(~v + 48'sd1) : v;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(~v + 64'sd1) : v;
    endfunction

    // Sign and magnitude to a clipped 48-bit value.
    function automatic t_clip clip48(input logic neg, input logic [63:0] m, input logic ovf);
        t_clip r;
        r.sat = 1'b0;
        if (neg) begin
            if (ovf || m > NEG_MAG) begin
                r.sat = 1'b1;
                r.val = {1'b1, 47'b0};
            end else begin
                r.val = 48'(~m + 64'd1);
            end
        end else begin
            if (ovf || m > POS_MAX) begin
                r.sat = 1'b1;
                r.val = {1'b0, {47{1'b1}}};
            end else begin
                r.val = m[47:0];
            end
        end
        return r;
    endfunction

    function automatic t_clip sat_s(input logic signed [63:0] v);
        return clip48(v[63], mag64(v), 1'b0);
    endfunction

endpackage

// ===== hw/rtl/lu_doolittle_factor_3x3.sv =====
// Top level of the 3x3 Doolittle LU factor pipeline.
//
//  channel | valid       | ready       | word        | moves
//  --------+-------------+-------------+-------------+-------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_word   | nine 16-bit coefficients
//  output  | o_out_valid | i_out_ready | o_out_word  | L and U factors, flags
//
// One matrix is accepted per cycle while the skid stage is empty. A matrix passes
// through the first divider, two stages that form u11, u12 and the l21 numerator,
// the second 48-bit divider, the multiplier and the output register.
// Reset is synchronous and clears only the valid bits.
// When the output stalls, one more word drops into the skid stage and the whole
// pipe then holds in place until the skid stage empties.
`timescale 1ns / 1ps
`include "lu_doolittle_factor_3x3_assert.svh"
module lu_doolittle_factor_3x3 #(
    parameter int FRAC_BITS = ludf_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ludf_pkg::t_coef   i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ludf_pkg::t_result o_out_word
);

    localparam int D1_W   = 16;
    localparam int Q1_W   = FRAC_BITS + 16;
    localparam int N1_W   = Q1_W + D1_W;
    localparam int D2_W   = 48;
    localparam int Q2_W   = 48;
    localparam int N2_W   = Q2_W + D2_W;
    localparam int C_W    = $bits(ludf_pkg::t_coef);
    localparam int P1_W   = C_W + 1;
    localparam int MID_W  = $bits(ludf_pkg::t_mid);
    localparam int MID2_W = $bits(ludf_pkg::t_mid2);
    localparam int RES_W  = $bits(ludf_pkg::t_result);

    logic en;

    // First division: l10 and l20 over a00.
    logic [15:0]     c_a00_mag;
    logic [15:0]     c_a10_mag;
    logic [15:0]     c_a20_mag;
    logic            d1a_valid, d1b_valid;
    logic [Q1_W:0]   d1a_quo, d1b_quo;
    logic            d1a_ovf, d1b_ovf;
    logic [P1_W-1:0] d1a_pay;
    logic            d1b_pay;

    assign c_a00_mag = ludf_pkg::mag16(i_in_word.coef_r0c0);
    assign c_a10_mag = ludf_pkg::mag16(i_in_word.coef_r1c0);
    assign c_a20_mag = ludf_pkg::mag16(i_in_word.coef_r2c0);

    ludf_div #(.DEN_W(D1_W), .QUO_W(Q1_W), .NUM_W(N1_W), .PAY_W(P1_W)) u_div_l10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_num   (N1_W'(c_a10_mag) << FRAC_BITS),
        .i_den   (c_a00_mag),
        .i_pay   ({i_in_word, i_in_word.coef_r1c0[15] ^ i_in_word.coef_r0c0[15]}),
        .o_valid (d1a_valid),
        .o_quo   (d1a_quo),
        .o_ovf   (d1a_ovf),
        .o_pay   (d1a_pay)
    );

    ludf_div #(.DEN_W(D1_W), .QUO_W(Q1_W), .NUM_W(N1_W), .PAY_W(1)) u_div_l20 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_num   (N1_W'(c_a20_mag) << FRAC_BITS),
        .i_den   (c_a00_mag),
        .i_pay   (i_in_word.coef_r2c0[15] ^ i_in_word.coef_r0c0[15]),
        .o_valid (d1b_valid),
        .o_quo   (d1b_quo),
        .o_ovf   (d1b_ovf),
        .o_pay   (d1b_pay)
    );

    // Stage 1: clip l10, l20 and form the four products with row 0.
    ludf_pkg::t_coef    c_d1_coef;
    ludf_pkg::t_clip    c_l10;
    ludf_pkg::t_clip    c_l20;
    logic signed [63:0] n_s1_p1, n_s1_p2, n_s1_p3, n_s1_p4;
    logic               r_s1_v;
    ludf_pkg::t_coef    r_s1_coef;
    logic signed [47:0] r_s1_l10, r_s1_l20;
    logic               r_s1_sat;
    logic signed [63:0] r_s1_p1, r_s1_p2, r_s1_p3, r_s1_p4;

    assign c_d1_coef = ludf_pkg::t_coef'(d1a_pay[P1_W-1:1]);
    assign c_l10     = ludf_pkg::clip48(d1a_pay[0], 64'(d1a_quo), d1a_ovf);
    assign c_l20     = ludf_pkg::clip48(d1b_pay, 64'(d1b_quo), d1b_ovf);
    assign n_s1_p1   = c_l10.val * c_d1_coef.coef_r0c1;
    assign n_s1_p2   = c_l10.val * c_d1_coef.coef_r0c2;
    assign n_s1_p3   = c_l20.val * c_d1_coef.coef_r0c1;
    assign n_s1_p4   = c_l20.val * c_d1_coef.coef_r0c2;

    // Stage 2: u11, u12, the l21 numerator and the exact part of u22.
    logic signed [63:0] c_u11_raw, c_u12_raw, n_s2_n21, c_r22;
    ludf_pkg::t_clip    c_u11, c_u12;
    ludf_pkg::t_mid     n_s2_mid;
    logic               r_s2_v;
    ludf_pkg::t_mid     r_s2_mid;
    logic signed [63:0] r_s2_n21;

    assign c_u11_raw = (64'(r_s1_coef.coef_r1c1) <<< FRAC_BITS) - r_s1_p1;
    assign c_u12_raw = (64'(r_s1_coef.coef_r1c2) <<< FRAC_BITS) - r_s1_p2;
    assign n_s2_n21  = (64'(r_s1_coef.coef_r2c1) <<< FRAC_BITS) - r_s1_p3;
    assign c_r22     = (64'(r_s1_coef.coef_r2c2) <<< FRAC_BITS) - r_s1_p4;
    assign c_u11     = ludf_pkg::sat_s(c_u11_raw);
    assign c_u12     = ludf_pkg::sat_s(c_u12_raw);

    always_comb begin
        n_s2_mid.a00   = r_s1_coef.coef_r0c0;
        n_s2_mid.a01   = r_s1_coef.coef_r0c1;
        n_s2_mid.a02   = r_s1_coef.coef_r0c2;
        n_s2_mid.l10   = r_s1_l10;
        n_s2_mid.l20   = r_s1_l20;
        n_s2_mid.u11   = c_u11.val;
        n_s2_mid.u12   = c_u12.val;
        n_s2_mid.r22   = c_r22;
        n_s2_mid.neg21 = n_s2_n21[63] ^ c_u11.val[47];
        n_s2_mid.z0    = (r_s1_coef.coef_r0c0 == '0);
        n_s2_mid.sat   = r_s1_sat | c_u11.sat | c_u12.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= d1a_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_coef <= c_d1_coef;
            r_s1_l10  <= c_l10.val;
            r_s1_l20  <= c_l20.val;
            r_s1_sat  <= c_l10.sat | c_l20.sat;
            r_s1_p1   <= n_s1_p1;
            r_s1_p2   <= n_s1_p2;
            r_s1_p3   <= n_s1_p3;
            r_s1_p4   <= n_s1_p4;
            r_s2_mid  <= n_s2_mid;
            r_s2_n21  <= n_s2_n21;
        end
    end

    // Second division: l21 over u11.
    logic             d2_valid;
    logic [Q2_W:0]    d2_quo;
    logic             d2_ovf;
    logic [MID_W-1:0] d2_pay;
    ludf_pkg::t_mid   c_d2_mid;
    ludf_pkg::t_clip  c_l21;
    ludf_pkg::t_mid2  c_mul_in;

    ludf_div #(.DEN_W(D2_W), .QUO_W(Q2_W), .NUM_W(N2_W), .PAY_W(MID_W)) u_div_l21 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_num   (N2_W'(ludf_pkg::mag64(r_s2_n21)) << FRAC_BITS),
        .i_den   (ludf_pkg::mag48(r_s2_mid.u11)),
        .i_pay   (r_s2_mid),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_ovf   (d2_ovf),
        .o_pay   (d2_pay)
    );

    assign c_d2_mid       = ludf_pkg::t_mid'(d2_pay);
    assign c_l21          = ludf_pkg::clip48(c_d2_mid.neg21, 64'(d2_quo), d2_ovf);
    assign c_mul_in.mid   = c_d2_mid;
    assign c_mul_in.l21   = c_l21.val;
    assign c_mul_in.sat21 = c_l21.sat;

    // l21 * u12 for the last update of u22.
    logic               mul_valid;
    logic signed [63:0] mul_prod;
    logic [MID2_W-1:0]  mul_pay;

    ludf_mul #(.FRAC_BITS(FRAC_BITS), .PAY_W(MID2_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d2_valid),
        .i_a     (c_l21.val),
        .i_b     (c_d2_mid.u12),
        .i_pay   (c_mul_in),
        .o_valid (mul_valid),
        .o_prod  (mul_prod),
        .o_pay   (mul_pay)
    );

    // Final assembly, with zero pivots forcing their dependants to zero.
    ludf_pkg::t_mid2    c_fin;
    logic signed [63:0] c_u22_raw;
    ludf_pkg::t_clip    c_u22;
    logic               c_z1;
    ludf_pkg::t_result  c_res;
    logic [RES_W-1:0]   out_vec;

    assign c_fin     = ludf_pkg::t_mid2'(mul_pay);
    assign c_u22_raw = c_fin.mid.r22 - mul_prod;
    assign c_u22     = ludf_pkg::sat_s(c_u22_raw);
    assign c_z1      = (c_fin.mid.u11 == '0);

    always_comb begin
        c_res.upper_r0c0 = 48'(c_fin.mid.a00) <<< FRAC_BITS;
        c_res.upper_r0c1 = 48'(c_fin.mid.a01) <<< FRAC_BITS;
        c_res.upper_r0c2 = 48'(c_fin.mid.a02) <<< FRAC_BITS;
        c_res.upper_r1c1 = c_fin.mid.u11;
        c_res.upper_r1c2 = c_fin.mid.u12;
        c_res.upper_r2c2 = c_u22.val;
        c_res.lower_r1c0 = c_fin.mid.l10;
        c_res.lower_r2c0 = c_fin.mid.l20;
        c_res.lower_r2c1 = c_fin.l21;
        c_res.pivot_zero = c_fin.mid.z0 | c_z1;
        c_res.saturated  = c_fin.mid.sat | c_fin.sat21 | c_u22.sat;
        if (c_fin.mid.z0) begin
            c_res.upper_r1c1 = '0;
            c_res.upper_r1c2 = '0;
            c_res.upper_r2c2 = '0;
            c_res.lower_r1c0 = '0;
            c_res.lower_r2c0 = '0;
            c_res.lower_r2c1 = '0;
            c_res.saturated  = 1'b0;
        end else if (c_z1) begin
            c_res.upper_r2c2 = '0;
            c_res.lower_r2c1 = '0;
            c_res.saturated  = c_fin.mid.sat;
        end
    end

    ludf_skid #(.W(RES_W)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_word  (c_res),
        .o_en    (en),
        .o_valid (o_out_valid),
        .o_word  (out_vec),
        .i_ready (i_out_ready)
    );

    assign o_out_word = ludf_pkg::t_result'(out_vec);
    assign o_in_ready = en;

    `LUDF_ASSERT_IMP(a_div_lockstep, i_clk, i_rst_n, 1'b1, d1a_valid == d1b_valid, "first dividers out of step")
    `LUDF_ASSERT_IMP(a_first_pivot, i_clk, i_rst_n, o_out_valid && o_out_word.upper_r0c0 == '0, o_out_word.pivot_zero && !o_out_word.saturated && o_out_word.lower_r1c0 == '0, "zero a00 not flagged")
    `LUDF_ASSERT_IMP(a_pivot_forces, i_clk, i_rst_n, o_out_valid && o_out_word.pivot_zero, o_out_word.lower_r2c1 == '0 && o_out_word.upper_r2c2 == '0, "zero pivot left l21 or u22 set")
    `LUDF_ASSERT_IMP(a_pivot_flag, i_clk, i_rst_n, o_out_valid && !o_out_word.pivot_zero, o_out_word.upper_r1c1 != '0 && o_out_word.upper_r0c0 != '0, "nonzero pivots reported as zero")

endmodule

// ===== hw/rtl/ludf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
`timescale 1ns / 1ps
module ludf_div #(
    parameter int DEN_W = 16,
    parameter int QUO_W = 32,
    parameter int NUM_W = QUO_W + DEN_W,
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [QUO_W:0]   o_quo,
    output logic             o_ovf,
    output logic [PAY_W-1:0] o_pay
);

    logic [QUO_W:0]   r_vld;
    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    logic [PAY_W-1:0] r_pay [0:QUO_W];

    logic [DEN_W:0]   c_trial [1:QUO_W];
    logic             c_take  [1:QUO_W];
    logic [DEN_W-1:0] n_rem   [1:QUO_W];
    logic [QUO_W-1:0] n_quo   [1:QUO_W];

    logic             r_out_vld;
    logic [QUO_W:0]   r_out_quo;
    logic             r_out_ovf;
    logic [PAY_W-1:0] r_out_pay;
    logic             c_round;

    always_comb begin
        for (int k = 1; k <= QUO_W; k++) begin
            c_trial[k] = {r_rem[k-1], r_low[k-1][QUO_W-k]};
            c_take[k]  = c_trial[k] >= {1'b0, r_den[k-1]};
            n_rem[k]   = c_take[k] ? DEN_W'(c_trial[k] - {1'b0, r_den[k-1]})
                                   : c_trial[k][DEN_W-1:0];
            n_quo[k]   = r_quo[k-1];
            n_quo[k][QUO_W-k] = c_take[k];
        end
    end

    assign c_round = {r_rem[QUO_W], 1'b0} >= {1'b0, r_den[QUO_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= {r_vld[QUO_W-1:0], i_valid};
            r_out_vld <= r_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // The high part of the numerator must stay below the divisor, or
            // the quotient does not fit.
            r_rem[0] <= i_num[NUM_W-1:QUO_W];
            r_low[0] <= i_num[QUO_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= i_num[NUM_W-1:QUO_W] >= i_den;
            r_pay[0] <= i_pay;
            for (int k = 1; k <= QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= r_low[k-1];
                r_quo[k] <= n_quo[k];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_pay[k] <= r_pay[k-1];
            end
            r_out_quo <= {1'b0, r_quo[QUO_W]} + (QUO_W+1)'(c_round);
            r_out_ovf <= r_ovf[QUO_W];
            r_out_pay <= r_pay[QUO_W];
        end
    end

    assign o_valid = r_out_vld;
    assign o_quo   = r_out_quo;
    assign o_ovf   = r_out_ovf;
    assign o_pay   = r_out_pay;

endmodule

// ===== hw/rtl/ludf_mul.sv =====
// Three-stage signed 48x48 fixed-point multiply, rounded and clamped at 2^62.
`timescale 1ns / 1ps
module ludf_mul #(
    parameter int FRAC_BITS = ludf_pkg::FRAC_BITS_DEF,
    parameter int PAY_W     = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [47:0] i_a,
    input  logic signed [47:0] i_b,
    input  logic [PAY_W-1:0]   i_pay,
    output logic               o_valid,
    output logic signed [63:0] o_prod,
    output logic [PAY_W-1:0]   o_pay
);

    localparam logic [95:0] HALF = 96'(1) << (FRAC_BITS - 1);

    logic [47:0]        c_x;
    logic [47:0]        c_y;
    logic [2:0]         r_vld;
    logic [47:0]        r_pp00, r_pp01, r_pp10, r_pp11;
    logic [1:0]         r_neg;
    logic [PAY_W-1:0]   r_pay [0:2];
    logic [95:0]        r_sum;
    logic [95:0]        c_shift;
    logic [63:0]        c_m;
    logic signed [63:0] r_prod;

    assign c_x = ludf_pkg::mag48(i_a);
    assign c_y = ludf_pkg::mag48(i_b);

    assign c_shift = r_sum >> FRAC_BITS;
    assign c_m     = (c_shift > 96'(ludf_pkg::BIG_MAG)) ? ludf_pkg::BIG_MAG : c_shift[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp00   <= c_x[23:0]  * c_y[23:0];
            r_pp01   <= c_x[23:0]  * c_y[47:24];
            r_pp10   <= c_x[47:24] * c_y[23:0];
            r_pp11   <= c_x[47:24] * c_y[47:24];
            r_neg[0] <= i_a[47] ^ i_b[47];
            r_pay[0] <= i_pay;

            r_sum    <= 96'(r_pp00) + (96'(r_pp01) << 24) + (96'(r_pp10) << 24)
                        + (96'(r_pp11) << 48) + HALF;
            r_neg[1] <= r_neg[0];
            r_pay[1] <= r_pay[0];

            r_prod   <= r_neg[1] ? 64'(64'd0 - c_m) : c_m;
            r_pay[2] <= r_pay[1];
        end
    end

    assign o_valid = r_vld[2];
    assign o_prod  = r_prod;
    assign o_pay   = r_pay[2];

endmodule

// ===== hw/rtl/ludf_skid.sv =====
// Output register with a skid stage; holds the pipe while a word waits.
`timescale 1ns / 1ps
`include "lu_doolittle_factor_3x3_assert.svh"
module ludf_skid #(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_word,
    output logic         o_en,
    output logic         o_valid,
    output logic [W-1:0] o_word,
    input  logic         i_ready
);

    logic         r_out_v;
    logic         r_skid_v;
    logic [W-1:0] r_out;
    logic [W-1:0] r_skid;

    assign o_en    = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (i_ready || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_valid;
            end
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : i_word;
        end else if (!r_skid_v) begin
            r_skid <= i_word;
        end
    end

    `LUDF_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid full with output empty")
    `LUDF_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_v && i_ready, r_out_v && !r_skid_v, "skid word not moved to output")
    `LUDF_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, r_skid_v && !i_ready, r_skid_v && $stable(r_skid), "skid word lost while stalled")

endmodule

// ===== verif/tb_lu_doolittle_factor_3x3.sv =====
// Self-checking testbench for the 3x3 Doolittle LU factor pipeline.
`timescale 1ns / 1ps
module tb_lu_doolittle_factor_3x3;

    localparam int FB = ludf_pkg::FRAC_BITS_DEF;
    localparam logic [63:0] CAP62 = 64'h4000_0000_0000_0000;

    typedef struct {
        ludf_pkg::t_coef mat;
        bit              drain;
    } t_queued_mat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    ludf_pkg::t_coef   in_word = '0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    ludf_pkg::t_result o_out_word;

    t_queued_mat       queued_mats[$];
    ludf_pkg::t_result expected_factors[$];
    int                accepted_cnt = 0;
    int                checked_cnt = 0;
    int                fails = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    bit                calm = 1'b0;

    lu_doolittle_factor_3x3 #(.FRAC_BITS(FB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word (o_out_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sign and magnitude to a 48-bit value, clipping and flagging on overflow.
    function automatic longint clip_to48(input bit neg, input logic [63:0] m, input bit ovf,
                                         inout bit sat);
        if (neg) begin
            if (ovf || m > ludf_pkg::NEG_MAG) begin
                sat = 1'b1;
                return -longint'(ludf_pkg::NEG_MAG);
            end
            return -longint'(m);
        end
        if (ovf || m > ludf_pkg::POS_MAX) begin
            sat = 1'b1;
            return longint'(ludf_pkg::POS_MAX);
        end
        return longint'(m);
    endfunction

    function automatic longint sat_wide(input longint v, inout bit sat);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return clip_to48(v < 0, m, 1'b0, sat);
    endfunction

    // Rounded (num * 2^FB) / den, ties away from zero; quotients of 2^62 or more overflow.
    function automatic longint div_round(input longint num, input longint den, inout bit sat);
        logic [127:0] m, d, q, rm;
        bit           ovf;
        m = {64'b0, ((num < 0) ? 64'(-num) : 64'(num))} << FB;
        d = {64'b0, ((den < 0) ? 64'(-den) : 64'(den))};
        q = m / d;
        rm = m % d;
        ovf = q >= {64'b0, CAP62};
        if (!ovf && rm * 2 >= d) q = q + 1;
        return clip_to48((num < 0) != (den < 0), q[63:0], ovf, sat);
    endfunction

    // Rounded a*b / 2^FB with the magnitude held at 2^62.
    function automatic longint mul_round(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'b0, ((a < 0) ? 64'(-a) : 64'(a))} * {64'b0, ((b < 0) ? 64'(-b) : 64'(b))};
        p = (p + (128'd1 << (FB - 1))) >> FB;
        m = (p > {64'b0, CAP62}) ? CAP62 : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic ludf_pkg::t_result factor_lu(input ludf_pkg::t_coef c);
        longint            one, l10, l20, u11, u12, l21, t;
        bit                sat, pz;
        ludf_pkg::t_result r;
        one = longint'(1) << FB;
        sat = 1'b0;
        pz = 1'b0;
        r = '0;
        r.upper_r0c0 = 48'(c.coef_r0c0 * one);
        r.upper_r0c1 = 48'(c.coef_r0c1 * one);
        r.upper_r0c2 = 48'(c.coef_r0c2 * one);
        if (c.coef_r0c0 == 0) begin
            pz = 1'b1;
        end else begin
            l10 = div_round(c.coef_r1c0, c.coef_r0c0, sat);
            l20 = div_round(c.coef_r2c0, c.coef_r0c0, sat);
            u11 = sat_wide(c.coef_r1c1 * one - l10 * c.coef_r0c1, sat);
            u12 = sat_wide(c.coef_r1c2 * one - l10 * c.coef_r0c2, sat);
            r.upper_r1c1 = 48'(u11);
            r.upper_r1c2 = 48'(u12);
            r.lower_r1c0 = 48'(l10);
            r.lower_r2c0 = 48'(l20);
            if (u11 == 0) begin
                pz = 1'b1;
            end else begin
                l21 = div_round(c.coef_r2c1 * one - l20 * c.coef_r0c1, u11, sat);
                t = mul_round(l21, u12);
                r.upper_r2c2 = 48'(sat_wide(c.coef_r2c2 * one - l20 * c.coef_r0c2 - t, sat));
                r.lower_r2c1 = 48'(l21);
            end
        end
        r.pivot_zero = pz;
        r.saturated = sat;
        return r;
    endfunction

    task automatic check_field(input string nm, input logic [47:0] got, input logic [47:0] want);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, nm, $signed(want), $signed(got));
            fails++;
        end
    endtask

    task automatic add_mat(input int v[9], input bit drain);
        t_queued_mat q;
        q.mat = {16'(v[0]), 16'(v[1]), 16'(v[2]), 16'(v[3]), 16'(v[4]), 16'(v[5]),
                 16'(v[6]), 16'(v[7]), 16'(v[8])};
        q.drain = drain;
        queued_mats.push_back(q);
    endtask

    task automatic add_random(input bit drain);
        int v[9];
        int mode, k;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) v[i] = int'($signed(16'($urandom)));
        if (mode == 6 || mode == 7) begin
            for (int i = 0; i < 9; i++) v[i] = $urandom_range(0, 8) - 4;
        end else if (mode == 8) begin
            // First two entries of the second row a multiple of the first's, so the second pivot vanishes.
            k = $urandom_range(0, 16) - 8;
            v[0] = $urandom_range(1, 200) * ($urandom_range(0, 1) ? 1 : -1);
            v[1] = $urandom_range(0, 400) - 200;
            v[3] = k * v[0];
            v[4] = k * v[1];
        end else if (mode == 9) begin
            // A pivot of one LSB, which drives the later entries into clipping.
            v[0] = 3;
            v[1] = 3;
            v[3] = 1;
            v[4] = 1;
        end
        add_mat(v, drain);
    endtask

    always @(posedge i_clk) begin
        bit          acc;
        bit          nxt_valid;
        t_queued_mat nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            acc = in_valid && o_in_ready;
            nxt_valid = in_valid && !acc;
            if (acc) begin
                expected_factors.push_back(factor_lu(in_word));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (queued_mats.size() > 0 && !(queued_mats[0].drain &&
                             accepted_cnt + int'(acc) != checked_cnt)) begin
                    nxt = queued_mats.pop_front();
                    in_word <= nxt.mat;
                    nxt_valid = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 6);
                end
            end
            in_valid <= nxt_valid;
            calm <= queued_mats.size() < 150;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && accepted_cnt >= 300) begin
            // Long hold-off so the pipe and its skid stage fill and the input stalls.
            hold_done <= 1'b1;
            hold_left <= 400;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        ludf_pkg::t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            checked_cnt <= checked_cnt + 1;
            if (expected_factors.size() == 0) begin
                $display("%0t: word with none expected, got %h", $time, o_out_word);
                fails++;
            end else begin
                want = expected_factors.pop_front();
                check_field("upper_r0c0", o_out_word.upper_r0c0, want.upper_r0c0);
                check_field("upper_r0c1", o_out_word.upper_r0c1, want.upper_r0c1);
                check_field("upper_r0c2", o_out_word.upper_r0c2, want.upper_r0c2);
                check_field("upper_r1c1", o_out_word.upper_r1c1, want.upper_r1c1);
                check_field("upper_r1c2", o_out_word.upper_r1c2, want.upper_r1c2);
                check_field("upper_r2c2", o_out_word.upper_r2c2, want.upper_r2c2);
                check_field("lower_r1c0", o_out_word.lower_r1c0, want.lower_r1c0);
                check_field("lower_r2c0", o_out_word.lower_r2c0, want.lower_r2c0);
                check_field("lower_r2c1", o_out_word.lower_r2c1, want.lower_r2c1);
                check_field("pivot_zero", 48'(o_out_word.pivot_zero), 48'(want.pivot_zero));
                check_field("saturated", 48'(o_out_word.saturated), 48'(want.saturated));
            end
        end
    end

    initial begin
        add_mat('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
        add_mat('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b0);
        add_mat('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
                1'b0);
        add_mat('{0, 32767, -32768, 5, 6, 7, 8, 9, 10}, 1'b0);
        add_mat('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0);
        add_mat('{1, 2, 3, 2, 4, 5, 7, 8, 9}, 1'b0);
        add_mat('{3, 3, 1, 1, 1, 32767, -32768, 32767, 32767}, 1'b0);
        add_mat('{3, 3, -32768, 1, 1, -32768, 32767, -32768, -32768}, 1'b0);
        add_mat('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767}, 1'b0);
        add_mat('{1, -32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768}, 1'b0);
        add_mat('{2, 0, 0, 1, 1, 0, -1, 1, 1}, 1'b0);
        add_mat('{-3, -3, 5, 1, 1, 0, 2, -32768, 4}, 1'b0);
        add_mat('{-1, 32767, 32767, 32767, -32768, -32768, 32767, 1, -1}, 1'b0);
        add_mat('{7, -5, 3, -14, 10, 2, 21, 4, -9}, 1'b0);
        for (int n = 0; n < 850; n++) add_random(n == 150 || n == 600);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (queued_mats.size() > 0 || in_valid) @(posedge i_clk);
        while (accepted_cnt != checked_cnt) @(posedge i_clk);
        repeat (FB + 100) @(posedge i_clk);
        if (fails == 0 && expected_factors.size() == 0) begin
            $display("lu_doolittle_factor_3x3 test passed");
        end else begin
            $display("lu_doolittle_factor_3x3 test failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("lu_doolittle_factor_3x3 test failed");
        $finish;
    end

endmodule
